[design/jsep_pkg.sv]
package jsep_pkg;

  // Event codes reported on the result channel
  typedef enum logic [3:0] {
    EV_OPEN_ARRAY  = 4'd0,
    EV_OPEN_OBJECT = 4'd1,
    EV_CLOSE       = 4'd2,
    EV_NAME_BYTE   = 4'd3,
    EV_NAME_END    = 4'd4,
    EV_STR_BYTE    = 4'd5,
    EV_STR_END     = 4'd6,
    EV_NUMBER      = 4'd7,
    EV_NULL        = 4'd8,
    EV_TRUE        = 4'd9,
    EV_FALSE       = 4'd10,
    EV_UNKNOWN     = 4'd11,
    EV_OVERFLOW    = 4'd12,
    EV_END         = 4'd13
  } event_t;

  localparam int NUM_W = 63;
  localparam int LIT_W = 40;

  localparam logic [NUM_W-1:0] NUM_MAX   = {NUM_W{1'b1}};
  localparam logic [LIT_W-1:0] LIT_NULL  = 40'h006E756C6C;
  localparam logic [LIT_W-1:0] LIT_TRUE  = 40'h0074727565;
  localparam logic [LIT_W-1:0] LIT_FALSE = 40'h66616C7365;

  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_COMMA  = 8'h2C;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_RBRACK = 8'h5D;
  localparam logic [7:0] CH_LBRACE = 8'h7B;
  localparam logic [7:0] CH_RBRACE = 8'h7D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_DEL    = 8'h7F;

endpackage

[design/jsep_in_if.sv]
interface jsep_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       end_of_text;

  modport source (output valid, output text_byte, output end_of_text, input ready);
  modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

[design/jsep_out_if.sv]
interface jsep_out_if;
  logic                        valid;
  logic                        ready;
  jsep_pkg::event_t            event_code;
  logic [7:0]                  event_byte;
  logic [jsep_pkg::NUM_W-1:0]  number_value;
  logic [5:0]                  nesting_level;
  logic                        last_of_run;

  modport source (output valid, output event_code, output event_byte, output number_value,
                  output nesting_level, output last_of_run, input ready);
  modport sink   (input valid, input event_code, input event_byte, input number_value,
                  input nesting_level, input last_of_run, output ready);
endinterface

[design/jsep_ram.sv]
module jsep_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 36
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/json_structure_event_parser.sv]
// The events of a byte are in the output queue in the cycle after its transfer.
// Throughput: one byte per cycle while each byte gives at most one event and the output is
// not held back; a byte that gives two events is handed out one event at a time by the single result port.
// Reset (rst_n low, synchronous): array state, state level cleared, nesting level -1, queue empty. The
// state stack RAM is not cleared; its top entry is cached in a register.
module json_structure_event_parser #(
  parameter int NODE_DEPTH  = 32,
  parameter int STATE_DEPTH = 36
) (
  input  logic       clk,
  input  logic       rst_n,
  jsep_in_if.sink    in_chan,
  jsep_out_if.source out_chan
);
  import jsep_pkg::*;

  localparam int AW    = $clog2(STATE_DEPTH);
  localparam int QD    = 4;
  localparam int QAW   = 2;
  localparam logic signed [7:0] NODE_LIM  = 8'(NODE_DEPTH);
  localparam logic signed [7:0] STATE_LIM = 8'(STATE_DEPTH);

  typedef enum logic [3:0] {
    ST_IDLE = 4'd0,
    ST_ESC  = 4'd1,
    ST_VAL  = 4'd2,
    ST_COL  = 4'd3,
    ST_AFT  = 4'd4,
    ST_ARR  = 4'd5,
    ST_OBJ  = 4'd6,
    ST_KEY  = 4'd7,
    ST_STR  = 4'd8,
    ST_NUM  = 4'd9,
    ST_LIT  = 4'd10
  } pstate_t;

  typedef struct packed {
    event_t           code;
    logic [7:0]       ebyte;
    logic [NUM_W-1:0] num;
    logic [5:0]       level;
    logic             last;
  } result_t;

  // parser state
  pstate_t            state_r, state_nxt;
  pstate_t            top_r, top_nxt;
  logic signed [7:0]  slvl_r, slvl_nxt;
  logic signed [7:0]  nlvl_r, nlvl_nxt;
  logic [NUM_W-1:0]   acc_r, acc_nxt;
  logic               nstop_r, nstop_nxt;
  logic [LIT_W-1:0]   lit_r, lit_nxt;
  logic [2:0]         llen_r, llen_nxt;
  logic               halted_r, halted_nxt;

  // output queue
  result_t            q_r [QD];
  logic [QAW-1:0]     wptr_r, rptr_r;
  logic [2:0]         cnt_r;

  // stack RAM
  logic               st_we;
  logic [AW-1:0]      st_raddr;
  logic [3:0]         st_rdata;
  logic signed [7:0]  rd_lvl;

  logic               acc_in, pop_out;
  logic [7:0]         b;
  logic               hit, carry, close_row;
  pstate_t            to_st, nx;
  logic signed [2:0]  dn;
  logic signed [1:0]  ds;
  logic signed [7:0]  nn, ns;
  logic signed [8:0]  lvl_p1;
  logic [5:0]         lvl_out;
  logic [NUM_W+3:0]   num_full;
  logic [3:0]         digit;
  logic               cs_rec, nx_rec;
  result_t            ev_a, ev_b, ev_c, ev0, ev1;
  logic               va, vb, vc;
  logic [1:0]         nev;

  assign b       = in_chan.text_byte;
  assign acc_in  = in_chan.valid && in_chan.ready;
  assign pop_out = out_chan.valid && out_chan.ready;
  assign cs_rec  = (state_r >= ST_KEY) && (state_r <= ST_LIT);

  // transition table lookup
  always_comb begin
    hit = 1'b0; to_st = state_r; dn = '0; ds = '0; carry = 1'b0; close_row = 1'b0;
    case (state_r)
      ST_OBJ: begin
        if (b == CH_QUOTE) begin
          hit = 1'b1; to_st = ST_KEY; dn = 3'sd1; ds = 2'sd1;
        end else if (b == CH_RBRACE) begin
          hit = 1'b1; to_st = ST_AFT; dn = -3'sd1; close_row = 1'b1;
        end
      end
      ST_KEY: begin
        if (b == CH_QUOTE) begin
          hit = 1'b1; to_st = ST_COL;
        end else if (b == CH_BSLASH) begin
          hit = 1'b1; to_st = ST_ESC; ds = 2'sd1;
        end
      end
      ST_COL: begin
        if (b == CH_COLON) begin
          hit = 1'b1; to_st = ST_VAL;
        end
      end
      ST_STR: begin
        if (b == CH_BSLASH) begin
          hit = 1'b1; to_st = ST_ESC; ds = 2'sd1;
        end else if (b == CH_QUOTE) begin
          hit = 1'b1; to_st = ST_AFT; dn = -3'sd1;
        end
      end
      ST_ESC: begin
        hit = 1'b1; to_st = ST_IDLE; ds = -2'sd1; carry = 1'b1;
      end
      ST_VAL: begin
        hit = 1'b1;
        if (b == CH_LBRACK) to_st = ST_ARR;
        else if (b == CH_LBRACE) to_st = ST_OBJ;
        else if (b >= CH_ZERO && b <= CH_NINE) begin
          to_st = ST_NUM; carry = 1'b1;
        end else if (b == CH_QUOTE) to_st = ST_STR;
        else begin
          to_st = ST_LIT; carry = 1'b1;
        end
      end
      ST_ARR: begin
        hit = 1'b1;
        if (b == CH_RBRACK) begin
          to_st = ST_AFT; dn = -3'sd1; close_row = 1'b1;
        end else begin
          dn = 3'sd1; ds = 2'sd1;
          if (b == CH_LBRACK) to_st = ST_ARR;
          else if (b == CH_LBRACE) to_st = ST_OBJ;
          else if (b >= CH_ZERO && b <= CH_NINE) begin
            to_st = ST_NUM; carry = 1'b1;
          end else if (b == CH_QUOTE) to_st = ST_STR;
          else begin
            to_st = ST_LIT; carry = 1'b1;
          end
        end
      end
      ST_NUM, ST_LIT: begin
        if (b == CH_COMMA) begin
          hit = 1'b1; to_st = ST_IDLE; dn = -3'sd1; ds = -2'sd1;
        end else if (b == CH_RBRACK || b == CH_RBRACE) begin
          hit = 1'b1; to_st = ST_AFT; dn = -3'sd2; ds = -2'sd1; close_row = 1'b1;
        end
      end
      ST_AFT: begin
        if (b == CH_COMMA) begin
          hit = 1'b1; to_st = ST_IDLE; ds = -2'sd1;
        end else if (b == CH_RBRACK || b == CH_RBRACE) begin
          hit = 1'b1; to_st = ST_AFT; dn = -3'sd1; ds = -2'sd1; close_row = 1'b1;
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

  // decimal accumulate with saturation
  assign digit    = b[3:0] - CH_ZERO[3:0];
  assign num_full = {acc_r, 3'b000} + {3'b000, acc_r, 1'b0} + {63'd0, digit};

  // per-byte update and event generation
  always_comb begin
    state_nxt = state_r; top_nxt = top_r; slvl_nxt = slvl_r; nlvl_nxt = nlvl_r;
    acc_nxt = acc_r; nstop_nxt = nstop_r; lit_nxt = lit_r; llen_nxt = llen_r;
    halted_nxt = halted_r;
    st_we = 1'b0;
    va = 1'b0; vb = 1'b0; vc = 1'b0;
    ev_a = '0; ev_b = '0; ev_c = '0;
    nn = nlvl_r + {{5{dn[2]}}, dn};
    ns = slvl_r + {{6{ds[1]}}, ds};
    nx = hit ? to_st : state_r;
    nx_rec = 1'b0;
    if (acc_in) begin
      if (in_chan.end_of_text || b == 8'd0) begin
        halted_nxt = 1'b1;
        va = 1'b1; ev_a.code = EV_END;
      end else if (!halted_r && (cs_rec || (b > CH_SPACE && b < CH_DEL))) begin
        if (nn >= NODE_LIM || ns >= STATE_LIM) begin
          halted_nxt = 1'b1;
          va = 1'b1; ev_a.code = EV_OVERFLOW;
        end else begin
          // stack push or pop
          if (ns > slvl_r && state_r != ST_IDLE) begin
            st_we = (slvl_r >= 0);
          end else if (ns < slvl_r && nx == ST_IDLE) begin
            nx = (ns >= 0) ? top_r : ST_IDLE;
          end
          if (ns > slvl_r) top_nxt = state_r;
          else if (ns < slvl_r) top_nxt = pstate_t'(st_rdata);
          nx_rec = (nx >= ST_KEY) && (nx <= ST_LIT);

          // open events
          if ((nx == ST_ARR || nx == ST_OBJ) && (b == CH_LBRACK || b == CH_LBRACE)) begin
            va = 1'b1;
            ev_a.code = (b == CH_LBRACK) ? EV_OPEN_ARRAY : EV_OPEN_OBJECT;
          end

          // value end or value byte
          if (nx != ST_ESC) begin
            if (cs_rec && !nx_rec) begin
              vb = 1'b1;
              case (state_r)
                ST_KEY: ev_b.code = EV_NAME_END;
                ST_STR: ev_b.code = EV_STR_END;
                ST_NUM: begin
                  ev_b.code = EV_NUMBER; ev_b.num = acc_r;
                end
                default: begin
                  if (llen_r == 3'd4 && lit_r == LIT_NULL) ev_b.code = EV_NULL;
                  else if (llen_r == 3'd4 && lit_r == LIT_TRUE) ev_b.code = EV_TRUE;
                  else if (llen_r == 3'd5 && lit_r == LIT_FALSE) ev_b.code = EV_FALSE;
                  else ev_b.code = EV_UNKNOWN;
                end
              endcase
              acc_nxt = '0; nstop_nxt = 1'b0; lit_nxt = '0; llen_nxt = '0;
            end else if (carry || cs_rec) begin
              case (nx)
                ST_KEY: begin
                  vb = 1'b1; ev_b.code = EV_NAME_BYTE; ev_b.ebyte = b;
                end
                ST_STR: begin
                  vb = 1'b1; ev_b.code = EV_STR_BYTE; ev_b.ebyte = b;
                end
                ST_NUM: begin
                  if (!nstop_r && b >= CH_ZERO && b <= CH_NINE) begin
                    acc_nxt = (num_full > {4'd0, NUM_MAX}) ? NUM_MAX : num_full[NUM_W-1:0];
                  end else begin
                    nstop_nxt = 1'b1;
                  end
                end
                ST_LIT: begin
                  if (llen_r < 3'd5) begin
                    lit_nxt  = {lit_r[LIT_W-9:0], b};
                    llen_nxt = llen_r + 3'd1;
                  end else begin
                    llen_nxt = 3'd6;
                  end
                end
                default: begin
                  vb = 1'b0;
                end
              endcase
            end
          end

          // close event
          if (close_row) begin
            vc = 1'b1; ev_c.code = EV_CLOSE;
          end

          nlvl_nxt  = nn;
          slvl_nxt  = ns;
          state_nxt = nx;
          if (nn < nlvl_r && nn < 0) halted_nxt = 1'b1;
        end
      end
    end
  end

  // nesting level after this byte, clamped to the port range
  assign lvl_p1  = {nlvl_nxt[7], nlvl_nxt} + 9'sd1;
  assign lvl_out = (lvl_p1 < 0) ? 6'd0 : (lvl_p1 > 9'sd63) ? 6'd63 : lvl_p1[5:0];

  // pack up to two events in order
  always_comb begin
    ev0 = va ? ev_a : (vb ? ev_b : ev_c);
    ev1 = va ? (vb ? ev_b : ev_c) : ev_c;
    nev = 2'({1'b0, va} + {1'b0, vb} + {1'b0, vc});
    ev0.level = lvl_out;
    ev1.level = lvl_out;
    ev0.last  = (nev == 2'd1);
    ev1.last  = 1'b1;
  end

  // stack read address tracks the entry below the cached top
  assign rd_lvl   = slvl_nxt - 8'sd2;
  assign st_raddr = (rd_lvl >= 0 && rd_lvl < STATE_LIM) ? rd_lvl[AW-1:0] : '0;

  jsep_ram #(
    .WIDTH (4),
    .DEPTH (STATE_DEPTH)
  ) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (slvl_r[AW-1:0]),
    .wdata (state_r),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // parser registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_ARR;
      top_r    <= ST_IDLE;
      slvl_r   <= '0;
      nlvl_r   <= -8'sd1;
      acc_r    <= '0;
      nstop_r  <= 1'b0;
      lit_r    <= '0;
      llen_r   <= '0;
      halted_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      top_r    <= top_nxt;
      slvl_r   <= slvl_nxt;
      nlvl_r   <= nlvl_nxt;
      acc_r    <= acc_nxt;
      nstop_r  <= nstop_nxt;
      lit_r    <= lit_nxt;
      llen_r   <= llen_nxt;
      halted_r <= halted_nxt;
    end
  end

  // output queue pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_r + QAW'(nev);
      rptr_r <= rptr_r + QAW'(pop_out);
      cnt_r  <= cnt_r + {1'b0, nev} - {2'b00, pop_out};
    end
  end

  // output queue payload
  always_ff @(posedge clk) begin
    if (nev != 2'd0) q_r[wptr_r] <= ev0;
    if (nev == 2'd2) q_r[wptr_r + QAW'(1)] <= ev1;
  end

  // no transfer is taken while reset is applied
  assign in_chan.ready          = rst_n && (cnt_r <= 3'(QD - 2));
  assign out_chan.valid         = (cnt_r != 3'd0);
  assign out_chan.event_code    = q_r[rptr_r].code;
  assign out_chan.event_byte    = q_r[rptr_r].ebyte;
  assign out_chan.number_value  = q_r[rptr_r].num;
  assign out_chan.nesting_level = q_r[rptr_r].level;
  assign out_chan.last_of_run   = q_r[rptr_r].last;

  // queue never overfills
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= 3'(QD))
    else $error("output queue count out of range");

  // end of text always halts the parser
  a_end_halts: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && in_chan.end_of_text |=> halted_r)
    else $error("end of text did not halt");

  // a halted parser adds nothing for ordinary bytes
  a_halt_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    acc_in && halted_r && !in_chan.end_of_text && b != 8'd0 |=> cnt_r <= $past(cnt_r))
    else $error("event produced while halted");

  // state level stays below stack depth
  a_slvl_bound: assert property (@(posedge clk) disable iff (!rst_n)
    slvl_r < STATE_LIM)
    else $error("state level beyond stack depth");

endmodule
